/* src/dct_pkg.sv */
// dct_pkg: shared types and constants for the deadline compare timer
// payload structs, register map, func codes, controller states and commands
// no dependencies

package dct_pkg;

   localparam int WRAP_WIDTH    = 32;
   localparam int COUNT_WIDTH   = 16;
   localparam int MOD_WIDTH     = COUNT_WIDTH + 1;
   localparam int TICK_WIDTH    = WRAP_WIDTH + COUNT_WIDTH + 1;
   localparam int DIV_CNT_WIDTH = $clog2(TICK_WIDTH);
   localparam int FUNC_WIDTH    = 3;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_IDX_WIDTH  = 2;

   localparam int PERIOD_COUNT_WIDTH = 16;
   localparam int PERIOD_WRAPS_WIDTH = 32;
   localparam int WRAP_LIMIT_WIDTH   = 16;

   localparam logic [WRAP_LIMIT_WIDTH-1:0] WRAP_LIMIT_RESET = 16'hFFFF;

   localparam logic [REG_IDX_WIDTH-1:0] REG_PERIOD_COUNT = 2'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_PERIOD_WRAPS = 2'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_WRAP_LIMIT   = 2'd2;

   localparam logic [FUNC_WIDTH-1:0] FUNC_START    = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_STOP     = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PERIODIC = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_ONESHOT  = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_CATCHUP  = 3'd4;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0]  func;
      logic [WRAP_WIDTH-1:0]  now_wraps;
      logic [COUNT_WIDTH-1:0] now_count;
   } req_type;

   typedef struct packed {
      logic                   fired;
      logic                   is_running;
      logic [WRAP_WIDTH-1:0]  deadline_wraps_out;
      logic [COUNT_WIDTH-1:0] deadline_count_out;
   } rsp_type;

   typedef struct packed {
      logic [PERIOD_COUNT_WIDTH-1:0] period_count;
      logic [PERIOD_WRAPS_WIDTH-1:0] period_wraps;
      logic [WRAP_LIMIT_WIDTH-1:0]   wrap_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CU_CHECK,
      ST_MUL_P,
      ST_MUL_N,
      ST_MUL_D,
      ST_CU_TEST,
      ST_WAIT_LATE,
      ST_CALC_T,
      ST_T_START,
      ST_WAIT_T,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_START,
      DP_STOP,
      DP_ONESHOT,
      DP_ADVANCE,
      DP_MUL_P,
      DP_MUL_N,
      DP_MUL_D,
      DP_DIV_LATE,
      DP_CALC_T,
      DP_DIV_T,
      DP_WRITE_Q
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic                  running;
      logic                  reached;
      logic                  period_zero;
      logic                  not_late;
      logic                  div_done;
   } status_type;

endpackage

/* src/dct_csr.sv */
// dct_csr: apb-style configuration registers of the deadline compare timer
// uses dct_pkg for the register map and the cfg_type struct

module dct_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [dct_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [dct_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [dct_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                  pready,
   output dct_pkg::cfg_type                      cfg
);

   localparam int DW = dct_pkg::CSR_DATA_WIDTH;

   dct_pkg::cfg_type                          cfg_ff;
   dct_pkg::cfg_type                          cfg_in;
   logic                                      wr_en;
   logic [dct_pkg::REG_IDX_WIDTH-1:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[dct_pkg::CSR_ADDR_WIDTH-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            dct_pkg::REG_PERIOD_COUNT: begin
               cfg_in.period_count = pwdata[dct_pkg::PERIOD_COUNT_WIDTH-1:0];
            end
            dct_pkg::REG_PERIOD_WRAPS: begin
               cfg_in.period_wraps = pwdata[dct_pkg::PERIOD_WRAPS_WIDTH-1:0];
            end
            dct_pkg::REG_WRAP_LIMIT: begin
               cfg_in.wrap_limit = pwdata[dct_pkg::WRAP_LIMIT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         dct_pkg::REG_PERIOD_COUNT: prdata = DW'(cfg_ff.period_count);
         dct_pkg::REG_PERIOD_WRAPS: prdata = DW'(cfg_ff.period_wraps);
         dct_pkg::REG_WRAP_LIMIT:   prdata = DW'(cfg_ff.wrap_limit);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_count <= '0;
         cfg_ff.period_wraps <= '0;
         cfg_ff.wrap_limit   <= dct_pkg::WRAP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/dct_divider.sv */
// dct_divider: restoring divider, one quotient bit per cycle
// uses dct_pkg for the tick width; shared by both catch-up divisions

module dct_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [dct_pkg::TICK_WIDTH-1:0]      dividend,
   input  logic [dct_pkg::TICK_WIDTH-1:0]      divisor,
   output logic [dct_pkg::TICK_WIDTH-1:0]      quotient,
   output logic [dct_pkg::TICK_WIDTH-1:0]      remainder,
   output logic                                done
);

   localparam int TW = dct_pkg::TICK_WIDTH;
   localparam int CW = dct_pkg::DIV_CNT_WIDTH;
   localparam logic [CW-1:0] LAST = CW'(TW - 1);

   logic [TW-1:0] rem_ff, rem_in;
   logic [TW-1:0] quo_ff, quo_in;
   logic [TW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [TW:0]   shifted;
   logic          ge;

   assign shifted   = {rem_ff, quo_ff[TW-1]};
   assign ge        = shifted >= {1'b0, dvs_ff};
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? TW'(shifted - {1'b0, dvs_ff}) : shifted[TW-1:0];
         quo_in = {quo_ff[TW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == LAST) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after last step");

endmodule

/* src/dct_datapath.sv */
// dct_datapath: deadline state, period arithmetic, shared multiplier and result register
// uses dct_pkg; instantiates dct_divider; driven by dct_ctrl commands

module dct_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  dct_pkg::cfg_type      cfg,
   input  dct_pkg::req_type      req_payload,
   input  dct_pkg::cmd_type      cmd,
   output dct_pkg::status_type   status,
   output dct_pkg::rsp_type      rsp_payload
);

   localparam int WW = dct_pkg::WRAP_WIDTH;
   localparam int CW = dct_pkg::COUNT_WIDTH;
   localparam int MW = dct_pkg::MOD_WIDTH;
   localparam int TW = dct_pkg::TICK_WIDTH;

   dct_pkg::req_type  item_ff, item_in;
   dct_pkg::rsp_type  rsp_ff, rsp_in;
   logic              running_ff, running_in;
   logic              fired_ff, fired_in;
   logic [WW-1:0]     dl_wraps_ff, dl_wraps_in;
   logic [CW-1:0]     dl_count_ff, dl_count_in;
   logic [TW-1:0]     p_ff, p_in;
   logic [TW-1:0]     nt_ff, nt_in;
   logic [TW-1:0]     dt_ff, dt_in;
   logic [TW-1:0]     t_ff, t_in;

   logic [MW-1:0]     modulus;
   logic [CW-1:0]     eff_count;
   logic              reached;
   logic [WW-1:0]     src_wraps;
   logic [CW-1:0]     src_count;
   logic [MW-1:0]     sum_count;
   logic              carry;
   logic [WW-1:0]     next_wraps;
   logic [CW-1:0]     next_count;
   logic [WW-1:0]     mul_a;
   logic [CW-1:0]     mul_add;
   logic [TW-1:0]     mul_res;
   logic [TW-1:0]     late;
   logic              div_start;
   logic [TW-1:0]     div_dividend;
   logic [TW-1:0]     div_divisor;
   logic [TW-1:0]     div_quo;
   logic [TW-1:0]     div_rem;
   logic              div_done;

   assign modulus   = {1'b0, cfg.wrap_limit[CW-1:0]} + MW'(1);
   assign eff_count = (cfg.period_count[CW-1:0] > cfg.wrap_limit[CW-1:0]) ?
                      cfg.wrap_limit[CW-1:0] : cfg.period_count[CW-1:0];

   assign reached = (item_ff.now_wraps == dl_wraps_ff && item_ff.now_count >= dl_count_ff) ||
                    (item_ff.now_wraps > dl_wraps_ff);

   // deadline, or the sampled time on start, plus one period with a single carry into the wrap part
   assign src_wraps  = (cmd.op == dct_pkg::DP_START) ? item_ff.now_wraps : dl_wraps_ff;
   assign src_count  = (cmd.op == dct_pkg::DP_START) ? item_ff.now_count : dl_count_ff;
   assign sum_count  = {1'b0, src_count} + {1'b0, eff_count};
   assign carry      = sum_count >= modulus;
   assign next_count = carry ? CW'(sum_count - modulus) : sum_count[CW-1:0];
   assign next_wraps = src_wraps + cfg.period_wraps[WW-1:0] + WW'(carry);

   // shared wraps * modulus + count
   always_comb begin
      case (cmd.op)
         dct_pkg::DP_MUL_P: begin
            mul_a   = cfg.period_wraps[WW-1:0];
            mul_add = eff_count;
         end
         dct_pkg::DP_MUL_N: begin
            mul_a   = item_ff.now_wraps;
            mul_add = item_ff.now_count;
         end
         default: begin
            mul_a   = dl_wraps_ff;
            mul_add = dl_count_ff;
         end
      endcase
   end

   assign mul_res = (TW'(mul_a) * TW'(modulus)) + TW'(mul_add);

   assign late         = nt_ff - dt_ff;
   assign div_start    = (cmd.op == dct_pkg::DP_DIV_LATE) || (cmd.op == dct_pkg::DP_DIV_T);
   assign div_dividend = (cmd.op == dct_pkg::DP_DIV_T) ? t_ff : late;
   assign div_divisor  = (cmd.op == dct_pkg::DP_DIV_T) ? TW'(modulus) : p_ff;

   dct_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_comb begin
      status.func        = item_ff.func;
      status.running     = running_ff;
      status.reached     = reached;
      status.period_zero = (p_ff == '0);
      status.not_late    = (nt_ff <= dt_ff);
      status.div_done    = div_done;
   end

   always_comb begin
      item_in     = item_ff;
      running_in  = running_ff;
      fired_in    = fired_ff;
      dl_wraps_in = dl_wraps_ff;
      dl_count_in = dl_count_ff;
      p_in        = p_ff;
      nt_in       = nt_ff;
      dt_in       = dt_ff;
      t_in        = t_ff;
      case (cmd.op)
         dct_pkg::DP_LOAD: begin
            item_in  = req_payload;
            fired_in = 1'b0;
         end
         dct_pkg::DP_START: begin
            dl_wraps_in = next_wraps;
            dl_count_in = next_count;
            running_in  = 1'b1;
         end
         dct_pkg::DP_STOP: begin
            running_in = 1'b0;
         end
         dct_pkg::DP_ONESHOT: begin
            running_in = 1'b0;
            fired_in   = 1'b1;
         end
         dct_pkg::DP_ADVANCE: begin
            dl_wraps_in = next_wraps;
            dl_count_in = next_count;
            fired_in    = 1'b1;
         end
         dct_pkg::DP_MUL_P: p_in  = mul_res;
         dct_pkg::DP_MUL_N: nt_in = mul_res;
         dct_pkg::DP_MUL_D: dt_in = mul_res;
         dct_pkg::DP_CALC_T: begin
            // whole periods up to or past now: round lateness up to a period multiple
            t_in = nt_ff + ((div_rem != '0) ? (p_ff - div_rem) : '0);
         end
         dct_pkg::DP_WRITE_Q: begin
            dl_wraps_in = div_quo[WW-1:0];
            dl_count_in = div_rem[CW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.fired              = fired_ff;
         rsp_in.is_running         = running_ff;
         rsp_in.deadline_wraps_out = dl_wraps_ff;
         rsp_in.deadline_count_out = dl_count_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         dl_wraps_ff <= '0;
         dl_count_ff <= '0;
      end else begin
         running_ff  <= running_in;
         dl_wraps_ff <= dl_wraps_in;
         dl_count_ff <= dl_count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      fired_ff <= fired_in;
      p_ff     <= p_in;
      nt_ff    <= nt_in;
      dt_ff    <= dt_in;
      t_ff     <= t_in;
      rsp_ff   <= rsp_in;
   end

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == dct_pkg::DP_START) |=> running_ff)
      else $error("start did not set running");

endmodule

/* src/dct_ctrl.sv */
// dct_ctrl: sequencing state machine of the deadline compare timer
// uses dct_pkg state, command and status types; drives dct_datapath

module dct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dct_pkg::status_type   status,
   output dct_pkg::cmd_type      cmd
);

   dct_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               poll_hit;

   assign req_ready = (state_ff == dct_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign poll_hit  = status.running && status.reached;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = dct_pkg::DP_NONE;
      cmd.rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         dct_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = dct_pkg::DP_LOAD;
               state_in = dct_pkg::ST_DECODE;
            end
         end
         dct_pkg::ST_DECODE: begin
            state_in = dct_pkg::ST_FINISH;
            case (status.func)
               dct_pkg::FUNC_START: cmd.op = dct_pkg::DP_START;
               dct_pkg::FUNC_STOP:  cmd.op = dct_pkg::DP_STOP;
               dct_pkg::FUNC_PERIODIC: begin
                  if (poll_hit) cmd.op = dct_pkg::DP_ADVANCE;
               end
               dct_pkg::FUNC_ONESHOT: begin
                  if (poll_hit) cmd.op = dct_pkg::DP_ONESHOT;
               end
               dct_pkg::FUNC_CATCHUP: begin
                  if (poll_hit) begin
                     cmd.op   = dct_pkg::DP_ADVANCE;
                     state_in = dct_pkg::ST_CU_CHECK;
                  end
               end
               default: begin
               end
            endcase
         end
         dct_pkg::ST_CU_CHECK: begin
            state_in = status.reached ? dct_pkg::ST_MUL_P : dct_pkg::ST_FINISH;
         end
         dct_pkg::ST_MUL_P: begin
            cmd.op   = dct_pkg::DP_MUL_P;
            state_in = dct_pkg::ST_MUL_N;
         end
         dct_pkg::ST_MUL_N: begin
            cmd.op   = dct_pkg::DP_MUL_N;
            state_in = dct_pkg::ST_MUL_D;
         end
         dct_pkg::ST_MUL_D: begin
            cmd.op   = dct_pkg::DP_MUL_D;
            state_in = dct_pkg::ST_CU_TEST;
         end
         dct_pkg::ST_CU_TEST: begin
            if (status.period_zero || status.not_late) begin
               state_in = dct_pkg::ST_FINISH;
            end else begin
               cmd.op   = dct_pkg::DP_DIV_LATE;
               state_in = dct_pkg::ST_WAIT_LATE;
            end
         end
         dct_pkg::ST_WAIT_LATE: begin
            if (status.div_done) state_in = dct_pkg::ST_CALC_T;
         end
         dct_pkg::ST_CALC_T: begin
            cmd.op   = dct_pkg::DP_CALC_T;
            state_in = dct_pkg::ST_T_START;
         end
         dct_pkg::ST_T_START: begin
            cmd.op   = dct_pkg::DP_DIV_T;
            state_in = dct_pkg::ST_WAIT_T;
         end
         dct_pkg::ST_WAIT_T: begin
            if (status.div_done) begin
               cmd.op   = dct_pkg::DP_WRITE_Q;
               state_in = dct_pkg::ST_FINISH;
            end
         end
         dct_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = dct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dct_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_late_div_then_t: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dct_pkg::ST_WAIT_LATE && status.div_done) |=>
      (state_ff == dct_pkg::ST_CALC_T))
      else $error("lateness division result not consumed");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == dct_pkg::DP_LOAD) |=> (state_ff == dct_pkg::ST_DECODE && !req_ready))
      else $error("accepted item not decoded");

endmodule

/* src/deadline_compare_timer_top.sv */
// deadline_compare_timer_top: compare-match timer on a wrap count plus counter time
// uses dct_pkg; instantiates dct_csr, dct_ctrl and dct_datapath
//
// usage
//   req channel (req_valid/req_ready/req_payload) carries one command with a
//   sampled time: start, stop, periodic poll, one-shot poll or catch-up poll
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) returns one result per
//   command: fired flag, running flag and the deadline after the command
//   apb-style port (psel ... pready) holds period_count at 0x0, period_wraps
//   at 0x4 and wrap_limit at 0x8; pready is always high
// timing
//   one item at a time; req_ready is high only while the sequencer is idle
//   start, stop, periodic, one-shot and plain polls pass through decode and finish;
//   the result is registered on leaving finish, and idle then takes the next item
//   catch-up polls that are late by more than one period run two divisions
//   in turn on the shared divider before finish
// reset
//   synchronous, active high: timer stopped, deadline zero, period zero,
//   wrap_limit 0xffff, no result pending
// stall
//   a result waits in the output register while rsp_ready is low; the next
//   item is still taken and processed, then held until that result is taken

module deadline_compare_timer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dct_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dct_pkg::rsp_type                   rsp_payload,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dct_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [dct_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [dct_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                               pready
);

   dct_pkg::cfg_type    cfg;
   dct_pkg::cmd_type    cmd;
   dct_pkg::status_type status;

   dct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dct_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking bench for deadline_compare_timer_top, predicts every result
// drives start, stop and poll commands on a monotonic time stream plus noise over several settings
// depends on dct_pkg and the rtl under src only

module tb_top;
   import dct_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int PRINT_LIMIT = 40;

   localparam logic [FUNC_WIDTH-1:0] FUNC_NOP_5 = 3'd5;
   localparam logic [FUNC_WIDTH-1:0] FUNC_NOP_6 = 3'd6;
   localparam logic [FUNC_WIDTH-1:0] FUNC_NOP_7 = 3'd7;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   rsp_type                   rsp_payload;
   logic                      psel        = 1'b0;
   logic                      penable     = 1'b0;
   logic                      pwrite      = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr       = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata      = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   logic [PERIOD_COUNT_WIDTH-1:0] cfg_period_count = '0;
   logic [PERIOD_WRAPS_WIDTH-1:0] cfg_period_wraps = '0;
   logic [WRAP_LIMIT_WIDTH-1:0]   cfg_wrap_limit   = WRAP_LIMIT_RESET;

   logic                   pred_running  = 1'b0;
   logic [WRAP_WIDTH-1:0]  pred_dl_wraps = '0;
   logic [COUNT_WIDTH-1:0] pred_dl_count = '0;

   req_type pending_cmds[$];
   rsp_type expected_results[$];

   int error_count     = 0;
   int cmds_accepted   = 0;
   int results_checked = 0;
   int fires_seen      = 0;
   int settings_used   = 0;
   int idle_cycles     = 0;

   logic        send_idle = 1'b1;
   logic        recv_idle = 1'b1;
   logic [4:0]  send_gap  = '0;
   logic [4:0]  recv_hold = '0;
   logic [63:0] gen_ticks = '0;

   deadline_compare_timer_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #2 clock = ~clock;

   // timer predictor

   function automatic logic [63:0] tick_modulus();
      return {48'd0, cfg_wrap_limit} + 64'd1;
   endfunction

   function automatic logic [63:0] step_count();
      return (cfg_period_count > cfg_wrap_limit) ? {48'd0, cfg_wrap_limit}
                                                 : {48'd0, cfg_period_count};
   endfunction

   function automatic logic [63:0] period_ticks();
      return {32'd0, cfg_period_wraps} * tick_modulus() + step_count();
   endfunction

   function automatic logic deadline_reached(input logic [WRAP_WIDTH-1:0] nw,
                                             input logic [COUNT_WIDTH-1:0] nc);
      return (nw == pred_dl_wraps && nc >= pred_dl_count) || nw > pred_dl_wraps;
   endfunction

   function automatic void add_period(input logic [63:0] w, input logic [63:0] c);
      c = c + step_count();
      w = w + {32'd0, cfg_period_wraps};
      if (c >= tick_modulus()) begin
         c = c - tick_modulus();
         w = w + 64'd1;
      end
      pred_dl_wraps = w[WRAP_WIDTH-1:0];
      pred_dl_count = c[COUNT_WIDTH-1:0];
   endfunction

   function automatic void skip_late_periods(input logic [63:0] nw, input logic [63:0] nc);
      logic [63:0] m, p, nt, dt, late, k, t, q, r;
      m  = tick_modulus();
      p  = period_ticks();
      nt = nw * m + nc;
      dt = {32'd0, pred_dl_wraps} * m + {48'd0, pred_dl_count};
      if (p != 64'd0 && nt > dt) begin
         late = nt - dt;
         k = late / p + ((late % p != 64'd0) ? 64'd1 : 64'd0);
         t = dt + k * p;
         q = t / m;
         r = t % m;
         pred_dl_wraps = q[WRAP_WIDTH-1:0];
         pred_dl_count = r[COUNT_WIDTH-1:0];
      end
   endfunction

   function automatic rsp_type run_timer_cmd(input req_type cmd);
      rsp_type res;
      res = '0;
      case (cmd.func)
         FUNC_START: begin
            add_period({32'd0, cmd.now_wraps}, {48'd0, cmd.now_count});
            pred_running = 1'b1;
         end
         FUNC_STOP: begin
            pred_running = 1'b0;
         end
         FUNC_PERIODIC, FUNC_ONESHOT, FUNC_CATCHUP: begin
            if (pred_running && deadline_reached(cmd.now_wraps, cmd.now_count)) begin
               res.fired = 1'b1;
               if (cmd.func == FUNC_ONESHOT) begin
                  pred_running = 1'b0;
               end else begin
                  add_period({32'd0, pred_dl_wraps}, {48'd0, pred_dl_count});
                  if (cmd.func == FUNC_CATCHUP && deadline_reached(cmd.now_wraps, cmd.now_count))
                     skip_late_periods({32'd0, cmd.now_wraps}, {48'd0, cmd.now_count});
               end
            end
         end
         default: begin
         end
      endcase
      res.is_running         = pred_running;
      res.deadline_wraps_out = pred_dl_wraps;
      res.deadline_count_out = pred_dl_count;
      return res;
   endfunction

   // stimulus helpers

   function automatic logic [63:0] rand_upto(input logic [63:0] n);
      logic [63:0] r;
      r = {$urandom, $urandom};
      return (n == '1) ? r : r % (n + 64'd1);
   endfunction

   function automatic req_type cmd_at(input logic [FUNC_WIDTH-1:0] f, input logic [63:0] ticks);
      req_type     c;
      logic [63:0] q;
      c.func = f;
      q = ticks / tick_modulus();
      c.now_wraps = q[WRAP_WIDTH-1:0];
      q = ticks % tick_modulus();
      c.now_count = q[COUNT_WIDTH-1:0];
      return c;
   endfunction

   task automatic queue_cmd(input logic [FUNC_WIDTH-1:0] f, input logic [WRAP_WIDTH-1:0] w,
                            input logic [COUNT_WIDTH-1:0] c);
      req_type cmd;
      cmd.func      = f;
      cmd.now_wraps = w;
      cmd.now_count = c;
      pending_cmds.push_back(cmd);
   endtask

   task automatic queue_random_cmds(input int count);
      logic [63:0]           p, delta;
      req_type               cmd;
      logic [FUNC_WIDTH-1:0] f;
      int                    sel, i;
      p = period_ticks();
      if ($urandom_range(0, 3) == 0)
         gen_ticks = {32'd0, 32'hFFFF_FFF0} * tick_modulus();
      else
         gen_ticks = rand_upto(64'd100000) * tick_modulus();
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            cmd.func      = FUNC_WIDTH'($urandom_range(0, 7));
            cmd.now_wraps = $urandom;
            cmd.now_count = COUNT_WIDTH'($urandom_range(0, 65535));
         end else begin
            case ($urandom_range(0, 9))
               0:             delta = 64'd0;
               1, 2, 3, 4, 5: delta = rand_upto(p / 2 + 64'd2);
               6, 7, 8:       delta = rand_upto(2 * p + 64'd2);
               default:       delta = rand_upto(8 * p + 64'd2);
            endcase
            gen_ticks = gen_ticks + delta;
            sel = $urandom_range(0, 99);
            if (sel < 12)
               f = FUNC_START;
            else if (sel < 17)
               f = FUNC_STOP;
            else if (sel < 47)
               f = FUNC_PERIODIC;
            else if (sel < 65)
               f = FUNC_ONESHOT;
            else
               f = FUNC_CATCHUP;
            cmd = cmd_at(f, gen_ticks);
         end
         pending_cmds.push_back(cmd);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch on result %0d, %s: got %0h, expected %0h",
                  results_checked, what, got, want);
      error_count++;
   endtask

   // write one register, then read it back
   task automatic csr_write(input logic [REG_IDX_WIDTH-1:0] idx, input logic [31:0] value);
      logic [31:0] readback, want;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      case (idx)
         REG_PERIOD_COUNT: cfg_period_count = value[PERIOD_COUNT_WIDTH-1:0];
         REG_PERIOD_WRAPS: cfg_period_wraps = value[PERIOD_WRAPS_WIDTH-1:0];
         REG_WRAP_LIMIT:   cfg_wrap_limit   = value[WRAP_LIMIT_WIDTH-1:0];
         default: begin
         end
      endcase
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_PERIOD_COUNT: want = {16'd0, cfg_period_count};
         REG_PERIOD_WRAPS: want = cfg_period_wraps;
         default:          want = {16'd0, cfg_wrap_limit};
      endcase
      if (readback !== want)
         report_mismatch("register readback", {32'd0, readback}, {32'd0, want});
   endtask

   task automatic set_timer_config(input logic [15:0] pc, input logic [31:0] pw,
                                   input logic [15:0] wl);
      wait_drained();
      csr_write(REG_PERIOD_COUNT, {16'd0, pc});
      csr_write(REG_PERIOD_WRAPS, pw);
      csr_write(REG_WRAP_LIMIT, {16'd0, wl});
      settings_used++;
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= '0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 5'd1;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            req_payload <= pending_cmds.pop_front();
            req_valid   <= 1'b1;
            if ($urandom_range(0, 39) == 0)
               send_idle = ~send_idle;
            send_gap <= send_idle ? 5'($urandom_range(0, 19)) : 5'd0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on command transfer, check on result transfer
   always @(posedge clock) begin
      rsp_type    exp_res;
      logic [4:0] hold_draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_hold <= '0;
      end else begin
         if (req_valid && req_ready) begin
            exp_res = run_timer_cmd(req_payload);
            expected_results.push_back(exp_res);
            cmds_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", 64'(rsp_payload), 64'd0);
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_payload.fired !== exp_res.fired)
                  report_mismatch("fired", 64'(rsp_payload.fired), 64'(exp_res.fired));
               if (rsp_payload.is_running !== exp_res.is_running)
                  report_mismatch("is_running", 64'(rsp_payload.is_running),
                                  64'(exp_res.is_running));
               if (rsp_payload.deadline_wraps_out !== exp_res.deadline_wraps_out)
                  report_mismatch("deadline_wraps_out", 64'(rsp_payload.deadline_wraps_out),
                                  64'(exp_res.deadline_wraps_out));
               if (rsp_payload.deadline_count_out !== exp_res.deadline_count_out)
                  report_mismatch("deadline_count_out", 64'(rsp_payload.deadline_count_out),
                                  64'(exp_res.deadline_count_out));
               if (exp_res.fired)
                  fires_seen++;
               results_checked++;
            end
            if ($urandom_range(0, 39) == 0)
               recv_idle = ~recv_idle;
            hold_draw = recv_idle ? 5'($urandom_range(0, 19)) : 5'd0;
            recv_hold <= hold_draw;
            rsp_ready <= (hold_draw == 5'd0);
         end else if (recv_hold != 0) begin
            recv_hold <= recv_hold - 5'd1;
            rsp_ready <= (recv_hold == 5'd1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: small modulus so carries show up
      set_timer_config(16'd4, 32'd2, 16'd9);
      queue_cmd(FUNC_PERIODIC, 32'd0, 16'd0);
      queue_cmd(FUNC_NOP_5, 32'd7, 16'd3);
      queue_cmd(FUNC_NOP_6, 32'hFFFF_FFFF, 16'hFFFF);
      queue_cmd(FUNC_NOP_7, 32'd0, 16'd0);
      queue_cmd(FUNC_START, 32'd100, 16'd8);
      queue_cmd(FUNC_PERIODIC, 32'd103, 16'd1);
      queue_cmd(FUNC_PERIODIC, 32'd103, 16'd2);
      queue_cmd(FUNC_PERIODIC, 32'd106, 16'd0);
      queue_cmd(FUNC_CATCHUP, 32'd200, 16'd5);
      queue_cmd(FUNC_START, 32'd300, 16'd0);
      queue_cmd(FUNC_CATCHUP, 32'd302, 16'd4);
      queue_cmd(FUNC_CATCHUP, 32'd304, 16'd9);
      queue_cmd(FUNC_CATCHUP, 32'd314, 16'd4);
      queue_cmd(FUNC_ONESHOT, 32'd400, 16'd0);
      queue_cmd(FUNC_ONESHOT, 32'd400, 16'd0);
      queue_cmd(FUNC_START, 32'hFFFF_FFFF, 16'd9);
      queue_cmd(FUNC_START, 32'hFFFF_FFFE, 16'd0);
      queue_cmd(FUNC_STOP, 32'd0, 16'd0);
      queue_cmd(FUNC_PERIODIC, 32'hFFFF_FFFF, 16'hFFFF);
      queue_cmd(FUNC_START, 32'd0, 16'hFFFF);
      queue_cmd(FUNC_PERIODIC, 32'hFFFF_FFFF, 16'hFFFF);

      // period count above the wrap limit
      set_timer_config(16'd50, 32'd2, 16'd9);
      queue_cmd(FUNC_START, 32'd10, 16'd5);
      queue_cmd(FUNC_CATCHUP, 32'd50, 16'd0);

      // zero period
      set_timer_config(16'd0, 32'd0, 16'd9);
      queue_cmd(FUNC_START, 32'd20, 16'd3);
      queue_cmd(FUNC_CATCHUP, 32'd25, 16'd0);
      queue_cmd(FUNC_PERIODIC, 32'd20, 16'd3);

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_timer_config(16'd1000, 32'd0, 16'hFFFF);
            1: set_timer_config(16'd0, 32'd0, 16'hFFFF);
            2: set_timer_config(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
            3: set_timer_config(16'd7, 32'd1, 16'd0);
            4: set_timer_config(16'd3, 32'd2, 16'd9);
            5: set_timer_config(16'($urandom), 32'($urandom_range(0, 20)), 16'($urandom));
            6: set_timer_config(16'($urandom), 32'($urandom_range(0, 3)),
                                16'($urandom_range(0, 300)));
            default: set_timer_config(16'd50, 32'd0, 16'd200);
         endcase
         queue_random_cmds(155);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("run covered %0d commands under %0d timer settings, %0d results checked",
               cmds_accepted, settings_used, results_checked);
      $display("%0d polls hit their deadline, %0d mismatches", fires_seen, error_count);
      if (error_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
src/dct_pkg.sv
src/dct_csr.sv
src/dct_divider.sv
src/dct_datapath.sv
src/dct_ctrl.sv
src/deadline_compare_timer_top.sv
dv/tb_top.sv
